### hdl/nps_pkg.sv
package nps_pkg;

    localparam int POINTS     = 1024;
    localparam int IDX_W      = $clog2(POINTS);
    localparam int CNT_W      = 11;
    localparam int SPAN_W     = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    localparam int ACT_W      = 2;
    localparam int PIDX_W     = 10;
    localparam int CENTER_W   = 10;
    localparam int OUT_IDX_W  = 10;
    localparam int COORD_W    = 18;
    localparam int QRY_W      = 12;
    localparam int FRAC_W     = 4;
    localparam int QPOS_W     = QRY_W + FRAC_W;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int ABS_W      = COORD_W;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int DSQ_W      = SQ_W + 1;
    localparam int RAD_W      = DSQ_W + 1;
    localparam int DIST_W     = 19;
    localparam int ENTRY_W    = 2 * COORD_W;
    localparam int HALF_SHIFT = 3;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FULL   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WINDOW = 2'd2;

    typedef struct packed {
        logic               is_load;
        logic               is_window;
        logic [IDX_W-1:0]   load_idx;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [QPOS_W-1:0]  qx;
        logic [QPOS_W-1:0]  qy;
        logic [SPAN_W-1:0]  lo;
        logic [SPAN_W-1:0]  hi;
    } cmd_t;

endpackage

### hdl/nps_in_if.sv
interface nps_in_if;
    logic                          valid;
    logic                          ready;
    logic [nps_pkg::ACT_W-1:0]     action;
    logic [nps_pkg::PIDX_W-1:0]    point_index;
    logic signed [nps_pkg::COORD_W-1:0] point_x;
    logic signed [nps_pkg::COORD_W-1:0] point_y;
    logic [nps_pkg::QRY_W-1:0]     query_row;
    logic [nps_pkg::QRY_W-1:0]     query_col;
    logic [nps_pkg::CENTER_W-1:0]  center_index;

    modport source (output valid, action, point_index, point_x, point_y, query_row,
                    query_col, center_index, input ready);
    modport sink   (input valid, action, point_index, point_x, point_y, query_row,
                    query_col, center_index, output ready);
endinterface

### hdl/nps_out_if.sv
interface nps_out_if;
    logic                           valid;
    logic                           ready;
    logic [nps_pkg::OUT_IDX_W-1:0]  nearest_index;
    logic [nps_pkg::DIST_W-1:0]     distance;
    logic                           found;

    modport source (output valid, nearest_index, distance, found, input ready);
    modport sink   (input valid, nearest_index, distance, found, output ready);
endinterface

### hdl/nps_cfg_if.sv
interface nps_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [nps_pkg::CNT_W-1:0]  point_count;

    modport source (output valid, point_count, input ready);
    modport sink   (input valid, point_count, output ready);
endinterface

### hdl/nps_front.sv
module nps_front (
    input  logic          clk,
    input  logic          rst_n,
    nps_in_if.sink        req,
    nps_cfg_if.sink       cfg,
    output logic          push_valid,
    input  logic          push_ready,
    output nps_pkg::cmd_t push_cmd
);

    logic [nps_pkg::CNT_W-1:0]  pc_reg;
    logic [nps_pkg::SPAN_W-1:0] n;
    logic [nps_pkg::SPAN_W-1:0] half;
    logic [nps_pkg::SPAN_W-1:0] ctr;
    logic [nps_pkg::SPAN_W-1:0] wlo;
    logic [nps_pkg::SPAN_W:0]   whi_raw;
    logic [nps_pkg::SPAN_W-1:0] whi;
    logic                       load_ok;
    logic                       is_load;
    logic                       is_full;
    logic                       is_window;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pc_reg <= nps_pkg::CNT_W'(1);
        end else if (cfg.valid) begin
            pc_reg <= cfg.point_count;
        end
    end

    always_comb begin
        is_load   = (req.action == nps_pkg::ACT_LOAD);
        is_full   = (req.action == nps_pkg::ACT_FULL);
        is_window = (req.action == nps_pkg::ACT_WINDOW);
        load_ok   = nps_pkg::SPAN_W'(req.point_index) < nps_pkg::SPAN_W'(nps_pkg::POINTS);

        n = (nps_pkg::SPAN_W'(pc_reg) > nps_pkg::SPAN_W'(nps_pkg::POINTS))
            ? nps_pkg::SPAN_W'(nps_pkg::POINTS) : nps_pkg::SPAN_W'(pc_reg);
        half    = n >> nps_pkg::HALF_SHIFT;
        ctr     = nps_pkg::SPAN_W'(req.center_index);
        wlo     = (ctr > half) ? ctr - half : '0;
        whi_raw = {1'b0, ctr} + {1'b0, half};
        whi     = (whi_raw > {1'b0, n}) ? n : whi_raw[nps_pkg::SPAN_W-1:0];

        push_cmd.is_load   = is_load;
        push_cmd.is_window = is_window;
        push_cmd.load_idx  = nps_pkg::IDX_W'(req.point_index);
        push_cmd.px        = req.point_x;
        push_cmd.py        = req.point_y;
        push_cmd.qx        = {req.query_col, {nps_pkg::FRAC_W{1'b0}}};
        push_cmd.qy        = {req.query_row, {nps_pkg::FRAC_W{1'b0}}};
        push_cmd.lo        = is_window ? wlo : '0;
        push_cmd.hi        = is_window ? whi : n;
    end

    // Unused actions and loads beyond the store are taken and dropped here.
    assign push_valid = req.valid && ((is_load && load_ok) || is_full || is_window);
    assign req.ready  = push_ready;

endmodule

### hdl/nps_queue.sv
module nps_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  nps_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output nps_pkg::cmd_t pop_cmd
);

    nps_pkg::cmd_t               slots [nps_pkg::QDEPTH];
    logic [nps_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [nps_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [nps_pkg::QPTR_W:0]    count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != nps_pkg::QDEPTH[nps_pkg::QPTR_W:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/nps_sqrt.sv
module nps_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nps_pkg::DSQ_W-1:0]   operand,
    output logic                        done,
    output logic [nps_pkg::DIST_W-1:0]  root
);

    logic [nps_pkg::RAD_W-1:0] v_reg;
    logic [nps_pkg::RAD_W-1:0] res_reg;
    logic [nps_pkg::RAD_W-1:0] bit_reg;
    logic [nps_pkg::RAD_W-1:0] v_next;
    logic [nps_pkg::RAD_W-1:0] res_next;
    logic [nps_pkg::RAD_W-1:0] bit_next;
    logic [nps_pkg::RAD_W-1:0] trial;
    logic                      busy_reg;
    logic                      done_reg;

    // One result bit per cycle, two radicand bits consumed per step.
    always_comb begin
        trial    = res_reg + bit_reg;
        bit_next = bit_reg >> 2;
        if (v_reg >= trial) begin
            v_next   = v_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end else begin
            v_next   = v_reg;
            res_next = res_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && bit_next == '0) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            v_reg   <= nps_pkg::RAD_W'(operand);
            res_reg <= '0;
            bit_reg <= nps_pkg::RAD_W'(1) << (nps_pkg::RAD_W - 2);
        end else if (busy_reg) begin
            v_reg   <= v_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[nps_pkg::DIST_W-1:0];

endmodule

### hdl/nps_back.sv
module nps_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  nps_pkg::cmd_t pop_cmd,
    nps_out_if.source     rsp
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_SQRT   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [nps_pkg::ENTRY_W-1:0] mem [nps_pkg::POINTS];

    logic                         is_window_reg;
    logic [nps_pkg::QPOS_W-1:0]   qx_reg;
    logic [nps_pkg::QPOS_W-1:0]   qy_reg;
    logic [nps_pkg::SPAN_W-1:0]   hi_reg;
    logic [nps_pkg::SPAN_W-1:0]   idx_reg;
    logic [nps_pkg::SPAN_W-1:0]   idx_inc;
    logic [nps_pkg::IDX_W-1:0]    rd_addr;

    logic                         p1_valid_reg;
    logic                         p2_valid_reg;
    logic                         p3_valid_reg;
    logic                         p4_valid_reg;
    logic [nps_pkg::IDX_W-1:0]    p1_idx_reg;
    logic [nps_pkg::IDX_W-1:0]    p2_idx_reg;
    logic [nps_pkg::IDX_W-1:0]    p3_idx_reg;
    logic [nps_pkg::IDX_W-1:0]    p4_idx_reg;
    logic [nps_pkg::ENTRY_W-1:0]  rdata_reg;
    logic [nps_pkg::ABS_W-1:0]    ax_reg;
    logic [nps_pkg::ABS_W-1:0]    ay_reg;
    logic [nps_pkg::SQ_W-1:0]     sqx_reg;
    logic [nps_pkg::SQ_W-1:0]     sqy_reg;
    logic [nps_pkg::DSQ_W-1:0]    d_reg;

    logic [nps_pkg::DIFF_W-1:0]   dx;
    logic [nps_pkg::DIFF_W-1:0]   dy;
    logic [nps_pkg::DIFF_W-1:0]   ndx;
    logic [nps_pkg::DIFF_W-1:0]   ndy;
    logic [nps_pkg::ABS_W-1:0]    ax;
    logic [nps_pkg::ABS_W-1:0]    ay;

    logic [nps_pkg::DSQ_W-1:0]    best_reg;
    logic [nps_pkg::IDX_W-1:0]    best_idx_reg;
    logic                         found_reg;

    logic                         rsp_valid_reg;
    logic [nps_pkg::OUT_IDX_W-1:0] nearest_reg;
    logic [nps_pkg::DIST_W-1:0]   dist_reg;
    logic                         found_out_reg;

    logic                         pop_take;
    logic                         pop_search;
    logic                         pop_empty;
    logic                         issue;
    logic                         pipe_busy;
    logic                         sq_start;
    logic                         sq_done;
    logic [nps_pkg::DIST_W-1:0]   sq_root;
    logic                         out_free;
    logic                         out_load;
    logic                         take_best;

    nps_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (best_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign pop_ready  = (state_reg == ST_IDLE);
    assign pop_take   = pop_valid && pop_ready;
    assign pop_search = pop_take && !pop_cmd.is_load;
    assign pop_empty  = pop_cmd.lo >= pop_cmd.hi;
    assign issue      = (state_reg == ST_SCAN);
    assign idx_inc    = idx_reg + 1'b1;
    assign rd_addr    = idx_reg[nps_pkg::IDX_W-1:0];
    assign pipe_busy  = p1_valid_reg || p2_valid_reg || p3_valid_reg || p4_valid_reg;
    assign sq_start   = (state_reg == ST_DRAIN) && !pipe_busy;
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign out_load   = (state_reg == ST_RESULT) && out_free;
    // Strict compare so that a tie keeps the earlier entry.
    assign take_best  = p4_valid_reg && (!found_reg || d_reg < best_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_search) begin
                    state_next = pop_empty ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_inc == hi_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sq_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        px_diff_calc: begin
            dx  = {rdata_reg[nps_pkg::COORD_W-1], rdata_reg[nps_pkg::COORD_W-1:0]}
                  - nps_pkg::DIFF_W'(qx_reg);
            dy  = {rdata_reg[nps_pkg::ENTRY_W-1], rdata_reg[nps_pkg::ENTRY_W-1:nps_pkg::COORD_W]}
                  - nps_pkg::DIFF_W'(qy_reg);
            ndx = '0 - dx;
            ndy = '0 - dy;
            ax  = dx[nps_pkg::DIFF_W-1] ? ndx[nps_pkg::ABS_W-1:0] : dx[nps_pkg::ABS_W-1:0];
            ay  = dy[nps_pkg::DIFF_W-1] ? ndy[nps_pkg::ABS_W-1:0] : dy[nps_pkg::ABS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            if (pop_search) begin
                found_reg <= 1'b0;
            end else if (take_best) begin
                found_reg <= 1'b1;
            end
            if (out_load) begin
                rsp_valid_reg <= 1'b1;
            end else if (rsp.ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pop_take && pop_cmd.is_load) begin
            mem[pop_cmd.load_idx] <= {pop_cmd.py, pop_cmd.px};
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk) begin
        if (pop_search) begin
            is_window_reg <= pop_cmd.is_window;
            qx_reg        <= pop_cmd.qx;
            qy_reg        <= pop_cmd.qy;
            hi_reg        <= pop_cmd.hi;
            idx_reg       <= pop_cmd.lo;
        end else if (issue) begin
            idx_reg <= idx_inc;
        end
        p1_idx_reg <= rd_addr;
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        p4_idx_reg <= p3_idx_reg;
        ax_reg     <= ax;
        ay_reg     <= ay;
        sqx_reg    <= ax_reg * ax_reg;
        sqy_reg    <= ay_reg * ay_reg;
        d_reg      <= nps_pkg::DSQ_W'(sqx_reg) + nps_pkg::DSQ_W'(sqy_reg);
        if (take_best) begin
            best_reg     <= d_reg;
            best_idx_reg <= p4_idx_reg;
        end
        if (out_load) begin
            found_out_reg <= found_reg;
            dist_reg      <= found_reg ? sq_root : '0;
            nearest_reg   <= (found_reg && !is_window_reg)
                             ? nps_pkg::OUT_IDX_W'(best_idx_reg) : '0;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.nearest_index = nearest_reg;
    assign rsp.distance      = dist_reg;
    assign rsp.found         = found_out_reg;

endmodule

### hdl/nearest_point_search_top.sv
// Load beat: queued, then written to the point store when the back end is idle.
// Search over m entries: scan through the distance pipeline, drain, square root, result;
// an empty window goes straight to the result. One search runs at a time, paced by the
// single store read port scanning one entry per cycle and the 19-step square root unit.
// Reset clears all control state and sets point_count to 1; the point store is not
// cleared and holds no defined contents until loaded.
module nearest_point_search_top (
    input  logic       clk,
    input  logic       rst_n,
    nps_in_if.sink     req,
    nps_out_if.source  rsp,
    nps_cfg_if.sink    cfg
);

    logic          push_valid;
    logic          push_ready;
    nps_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    nps_pkg::cmd_t pop_cmd;

    nps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    nps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    nps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp       (rsp)
    );

endmodule

### hdl/nps_checker.sv
module nps_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [nps_pkg::OUT_IDX_W-1:0]  nearest_index,
    input logic [nps_pkg::DIST_W-1:0]     distance,
    input logic                           found
);

    // A stalled result beat stays up.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(nearest_index) && $stable(distance)
            && $stable(found))
        else $error("result payload changed while stalled");

    // An empty search reports zero index and zero distance.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> nearest_index == '0 && distance == '0)
        else $error("empty search returned nonzero fields");

    // No result beat is shown during reset or in the cycle that follows it.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n || $past(!rst_n) |-> !rsp_valid)
        else $error("result beat around reset");

endmodule

bind nearest_point_search_top nps_checker u_nps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .nearest_index (rsp.nearest_index),
    .distance      (rsp.distance),
    .found         (rsp.found)
);
